// ===== hdl/prs_pkg.sv =====
// ----------------------------------------------------------------------------
// prs_pkg
// Shared types and constants of the polyphase resampler.
// ----------------------------------------------------------------------------
package prs_pkg;

  localparam int MODE_W     = 2;
  localparam int CIDX_W     = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int RES_LIMIT  = 64;
  localparam int CNT_W      = $clog2(RES_LIMIT + 1);

  localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_END    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_INTERP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECIM  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAPS   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALIGN  = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALIGN,
    S_CHECK,
    S_MAC,
    S_PUT,
    S_PAD,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic clr;
    logic en;
  } mac_ctl_t;

endpackage

// ===== hdl/prs_ram.sv =====
// ----------------------------------------------------------------------------
// prs_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module prs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/prs_mac.sv =====
// ----------------------------------------------------------------------------
// prs_mac
// Shared multiply-accumulate unit with round half up and saturation.
// ----------------------------------------------------------------------------
module prs_mac #(
  parameter int SW    = 16,
  parameter int CW    = 18,
  parameter int ACC_W = 42
) (
  input  logic                  clk,
  input  logic                  rst,
  input  prs_pkg::mac_ctl_t     ctl,
  input  logic signed [CW-1:0]  coef,
  input  logic signed [SW-1:0]  samp,
  output logic                  busy,
  output logic signed [SW-1:0]  result,
  output logic                  sat
);
  import prs_pkg::*;

  localparam int FRAC = CW - 4;
  localparam logic signed [ACC_W-1:0] HI = (ACC_W'(1) <<< (SW - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] LO = -HI - ACC_W'(1);

  logic signed [SW+CW-1:0] prod;
  logic                    prod_v;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] rnd;
  logic signed [ACC_W-1:0] q;

  always_ff @(posedge clk) begin
    prod <= coef * samp;
    if (rst) begin
      prod_v <= 1'b0;
    end else begin
      prod_v <= ctl.en;
    end
    if (ctl.clr) begin
      acc <= '0;
    end else if (prod_v) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  always_comb begin
    rnd = acc + (ACC_W'(1) <<< (FRAC - 1));
    q   = rnd >>> FRAC;
    sat = 1'b0;
    result = SW'(q);
    if (q > HI) begin
      result = SW'(HI);
      sat    = 1'b1;
    end else if (q < LO) begin
      result = SW'(LO);
      sat    = 1'b1;
    end
  end

  assign busy = prod_v;

endmodule

// ===== hdl/polyphase_resampler.sv =====
// ----------------------------------------------------------------------------
// polyphase_resampler
// Rational L/M resampler: upsample, FIR filter and decimate on one shared MAC.
// ----------------------------------------------------------------------------
// Load item: the coefficient is written on acceptance. Sample or end item:
// S_ALIGN setup, then per output S_CHECK, S_MAC over the taps of its phase and
// S_PUT, then S_FLUSH to close; the single MAC takes one tap per cycle, and no new item is taken before S_IDLE.
// Results wait in a one-word pending stage; a full output stalls the MAC loop.
// Reset (synchronous): registers to defaults, counters and fill count cleared;
// history is masked by the fill count, coefficients are undefined until loaded.
module polyphase_resampler #(
  parameter int MAX_TAPS     = 64,
  parameter int MAX_FACTOR   = 16,
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_WIDTH   = 18
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // coef_index, coef_value, sample
  input  logic [((prs_pkg::CIDX_W + COEF_WIDTH + SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
  // mode
  input  logic [prs_pkg::MODE_W-1:0] s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // result
  output logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] m_tdata,
  // saturated, signal_end
  output logic [1:0] m_tuser,
  output logic m_tlast,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [prs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [prs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import prs_pkg::*;

  localparam int AW    = MAX_TAPS > 1 ? $clog2(MAX_TAPS) : 1;
  localparam int PW    = $clog2(MAX_TAPS + 1);
  localparam int FW    = $clog2(MAX_FACTOR + 1);
  localparam int KW    = $clog2(MAX_TAPS + 2 * MAX_FACTOR + 2) + 1;
  localparam int NW    = 32 + FW;
  localparam int ACC_W = SAMPLE_WIDTH + COEF_WIDTH + AW + 2;
  localparam int OUT_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam logic [COEF_WIDTH-1:0] UNIT_COEF = COEF_WIDTH'(1) << (COEF_WIDTH - 4);

  state_t state, state_next;

  logic [4:0] interp_factor, decim_factor;
  logic [6:0] tap_count;
  logic       align_enable;

  logic [FW-1:0] lf, mf;
  logic [PW-1:0] pf, gd;

  logic [CIDX_W-1:0]       in_idx;
  logic [COEF_WIDTH-1:0]   in_coef;
  logic [SAMPLE_WIDTH-1:0] in_samp;
  logic                    accept;

  logic           is_end, padding, keep;
  logic [4:0]     off;
  logic [31:0]    seen, done_cnt;
  logic [PW-1:0]  fill, h;
  logic [AW-1:0]  newest;
  logic [KW-1:0]  pos, k, al;
  logic [PW-1:0]  st;
  logic [NW-1:0]  nl;
  logic [CNT_W-1:0] cnt;

  logic rd_v, rd_hv, rd_k0;
  logic iss, settled, out_free, idx_ge, in_win;
  logic word_load;

  logic signed [SAMPLE_WIDTH-1:0] cand, pend, res_q;
  logic cand_sat, pend_sat, pend_v, res_sat, last_q, send_q;

  mac_ctl_t mac_ctl;
  logic mac_busy, mac_sat;
  logic signed [SAMPLE_WIDTH-1:0] mac_res;
  logic signed [COEF_WIDTH-1:0]   mac_coef;
  logic signed [SAMPLE_WIDTH-1:0] mac_samp;

  logic                    coef_we, hist_we;
  logic [AW-1:0]           coef_waddr, coef_raddr, hist_waddr, hist_raddr;
  logic [COEF_WIDTH-1:0]   coef_rdata;
  logic [SAMPLE_WIDTH-1:0] hist_rdata;

  assign in_idx  = s_tdata[CIDX_W-1:0];
  assign in_coef = s_tdata[CIDX_W +: COEF_WIDTH];
  assign in_samp = s_tdata[CIDX_W + COEF_WIDTH +: SAMPLE_WIDTH];
  assign accept  = s_tvalid && s_tready;

  assign lf = (interp_factor == '0) ? FW'(1) :
              ((32'(interp_factor) > MAX_FACTOR) ? FW'(MAX_FACTOR) : FW'(interp_factor));
  assign mf = (decim_factor == '0) ? FW'(1) :
              ((32'(decim_factor) > MAX_FACTOR) ? FW'(MAX_FACTOR) : FW'(decim_factor));
  assign pf = (tap_count == '0) ? PW'(1) :
              ((32'(tap_count) > MAX_TAPS) ? PW'(MAX_TAPS) : PW'(tap_count));
  assign gd = (pf - PW'(1)) >> 1;

  assign iss      = (k < KW'(pf)) && (32'(h) < MAX_TAPS);
  assign settled  = !iss && !rd_v && !mac_busy;
  assign out_free = !m_tvalid || m_tready;
  assign idx_ge   = done_cnt >= 32'(st);
  assign in_win   = (NW'(done_cnt - 32'(st)) * NW'(mf)) < nl;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (s_tuser == MODE_SAMPLE) begin
            state_next = S_ALIGN;
          end else if (s_tuser == MODE_END) begin
            state_next = (seen != '0) ? S_ALIGN : S_FLUSH;
          end
        end
      end
      S_ALIGN: begin
        if (al >= KW'(gd)) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (!is_end) begin
          state_next = (pos < KW'(lf)) ? S_MAC : S_FLUSH;
        end else if (pos + KW'(2) <= KW'(pf)) begin
          state_next = S_MAC;
        end else begin
          state_next = align_enable ? S_PAD : S_FLUSH;
        end
      end
      S_MAC: begin
        if (settled) state_next = S_PUT;
      end
      S_PUT: begin
        if (32'(cnt) >= RES_LIMIT || !keep || !pend_v || out_free) begin
          state_next = padding ? S_PAD : S_CHECK;
        end
      end
      S_PAD: begin
        state_next = (in_win && 32'(cnt) < RES_LIMIT) ? S_PUT : S_FLUSH;
      end
      S_FLUSH: begin
        if (!pend_v || out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_tready    = (state == S_IDLE);
    cfg_ready   = 1'b1;
    mac_ctl.clr = (state == S_CHECK);
    mac_ctl.en  = rd_v;
    coef_we     = accept && (s_tuser == MODE_LOAD) && (32'(in_idx) < MAX_TAPS);
    coef_waddr  = AW'(in_idx);
    hist_we     = accept && (s_tuser == MODE_SAMPLE);
    hist_waddr  = newest + AW'(1);
    coef_raddr  = k[AW-1:0];
    hist_raddr  = newest - AW'(h);
    mac_coef    = rd_k0 ? UNIT_COEF : '0;
    if (tap_count != '0) mac_coef = coef_rdata;
    mac_samp    = rd_hv ? hist_rdata : '0;
    m_tdata     = OUT_W'(unsigned'(res_q));
    m_tuser     = {send_q, res_sat};
    m_tlast     = last_q;
    word_load   = pend_v && out_free &&
                  ((state == S_PUT && 32'(cnt) < RES_LIMIT && keep) || (state == S_FLUSH));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      interp_factor <= 5'd1;
      decim_factor  <= 5'd1;
      tap_count     <= '0;
      align_enable  <= 1'b0;
      off      <= '0;
      seen     <= '0;
      fill     <= '0;
      done_cnt <= '0;
      newest   <= '0;
      pend_v   <= 1'b0;
      m_tvalid <= 1'b0;
      rd_v     <= 1'b0;
      cnt      <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_INTERP: interp_factor <= cfg_data[4:0];
          REG_DECIM:  decim_factor  <= cfg_data[4:0];
          REG_TAPS:   tap_count     <= cfg_data;
          REG_ALIGN:  align_enable  <= cfg_data[0];
          default: ;
        endcase
      end
      if (word_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      rd_v  <= (state == S_MAC) && iss;
      rd_hv <= h < fill;
      rd_k0 <= (k == '0);

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            is_end  <= (s_tuser == MODE_END);
            cnt     <= '0;
            padding <= 1'b0;
            al      <= '0;
            st      <= '0;
            nl      <= NW'(seen) * NW'(lf);
            pos     <= KW'(off);
            if (s_tuser == MODE_SAMPLE) begin
              seen   <= seen + 32'd1;
              newest <= newest + AW'(1);
              if (32'(fill) < MAX_TAPS) fill <= fill + PW'(1);
            end
          end
        end
        S_ALIGN: begin
          if (al < KW'(gd)) begin
            al <= al + KW'(mf);
            st <= st + PW'(1);
          end
        end
        S_CHECK: begin
          k    <= is_end ? pos + KW'(lf) : pos;
          h    <= '0;
          keep <= is_end ? (!align_enable || (idx_ge && in_win)) : (!align_enable || idx_ge);
          if (!is_end && pos >= KW'(lf)) off <= 5'(pos - KW'(lf));
          if (is_end && pos + KW'(2) > KW'(pf)) begin
            padding <= 1'b1;
            if (!idx_ge) done_cnt <= 32'(st);
          end
        end
        S_MAC: begin
          if (iss) begin
            k <= k + KW'(lf);
            h <= h + PW'(1);
          end
          cand     <= mac_res;
          cand_sat <= mac_sat;
        end
        S_PUT: begin
          if (32'(cnt) >= RES_LIMIT || !keep || !pend_v || out_free) begin
            if (32'(cnt) < RES_LIMIT && keep) begin
              if (pend_v) begin
                res_q    <= pend;
                res_sat  <= pend_sat;
                last_q   <= 1'b0;
                send_q   <= 1'b0;
              end
              pend     <= cand;
              pend_sat <= cand_sat;
              pend_v   <= 1'b1;
              cnt      <= cnt + CNT_W'(1);
            end
            done_cnt <= done_cnt + 32'd1;
            if (!padding) pos <= pos + KW'(mf);
          end
        end
        S_PAD: begin
          cand     <= '0;
          cand_sat <= 1'b0;
          keep     <= 1'b1;
        end
        S_FLUSH: begin
          if (!pend_v || out_free) begin
            if (pend_v) begin
              res_q    <= pend;
              res_sat  <= pend_sat;
              last_q   <= 1'b1;
              send_q   <= is_end;
              pend_v   <= 1'b0;
            end
            if (is_end) begin
              seen     <= '0;
              fill     <= '0;
              off      <= '0;
              done_cnt <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  prs_ram #(.WIDTH(COEF_WIDTH), .DEPTH(MAX_TAPS)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (in_coef),
    .raddr (coef_raddr),
    .rdata (coef_rdata)
  );

  prs_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(1 << AW)) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (in_samp),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  prs_mac #(.SW(SAMPLE_WIDTH), .CW(COEF_WIDTH), .ACC_W(ACC_W)) u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mac_ctl),
    .coef   (mac_coef),
    .samp   (mac_samp),
    .busy   (mac_busy),
    .result (mac_res),
    .sat    (mac_sat)
  );

  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !pend_v)
    else $error("pending word left over after item");

  a_cnt_limit: assert property (@(posedge clk) disable iff (rst)
    32'(cnt) <= RES_LIMIT)
    else $error("result count above limit");

  a_fill_limit: assert property (@(posedge clk) disable iff (rst)
    32'(fill) <= MAX_TAPS)
    else $error("history fill count above depth");

  a_mac_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUT) |-> (!rd_v && !mac_busy))
    else $error("MAC still busy while result is taken");

endmodule
